/* src/ffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator: field widths,
// request codes, register map and the table entry layout.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // field widths
    localparam int OFFSET_BITS = 16;
    localparam int SIZE_BITS   = 17;
    localparam int FUNC_BITS   = 2;
    // cursor / end arithmetic needs headroom above the size width
    localparam int CUR_BITS    = SIZE_BITS + 1;
    localparam int ALIGN_BYTES = 8;

    // request codes
    typedef logic [FUNC_BITS-1:0] t_func;
    localparam t_func FUNC_ALLOC = 2'd0;
    localparam t_func FUNC_FREE  = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_REGION_BYTES = 1'b0;
    localparam logic [SIZE_BITS-1:0] REGION_RESET = 17'd4096;

    // largest region end the offset width can address
    localparam logic [CUR_BITS-1:0] REGION_CAP = CUR_BITS'(64'd1 << OFFSET_BITS);

    // one allocated block in the table
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [SIZE_BITS-1:0]   size;
    } t_entry;

    // round a byte count up to the alignment
    function automatic logic [CUR_BITS-1:0] round_up(input logic [CUR_BITS-1:0] x);
        logic [CUR_BITS-1:0] s;
        s = x + CUR_BITS'(ALIGN_BYTES - 1);
        return CUR_BITS'((s / ALIGN_BYTES) * ALIGN_BYTES);
    endfunction

endpackage

/* src/ffa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel of the allocator: valid/ready handshake with the request
// kind, requested size and target offset.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    import ffa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [SIZE_BITS-1:0]   request_bytes;
    logic [OFFSET_BITS-1:0] target_offset;

    modport source (output valid, func, request_bytes, target_offset, input ready);
    modport sink   (input valid, func, request_bytes, target_offset, output ready);
endinterface

/* src/ffa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel of the allocator: valid/ready handshake with the status,
// granted offset and block size.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [OFFSET_BITS-1:0] granted_offset;
    logic [SIZE_BITS-1:0]   found_bytes;

    modport source (output valid, ok, granted_offset, found_bytes, input ready);
    modport sink   (input valid, ok, granted_offset, found_bytes, output ready);
endinterface

/* src/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// The walk reads one table entry a cycle and stops at the first fit or match, then the
// insert or remove shift moves only the remaining entries, one a cycle.
// One request at a time: a new request is taken once the previous result sits in the
// output register.
// Reset clears the block count and loads the region size with 4096; the table is not cleared.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over one region: a sorted table of blocks in a memory,
// walked and shifted by a small sequencer with one shared compare datapath.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ffa_req_if.sink                        i_req,
    ffa_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffa_pkg::PADDR_BITS-1:0] paddr,
    input  logic [ffa_pkg::PDATA_BITS-1:0] pwdata,
    output logic [ffa_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);
    import ffa_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_FIND,
        ST_DEL,
        ST_RESP
    } t_state;

    // sequencer and datapath registers
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_pos, n_pos;
    logic [CUR_BITS-1:0]    r_cursor, n_cursor;
    logic [CUR_BITS-1:0]    r_need, n_need;
    logic [CUR_BITS-1:0]    r_end, n_end;
    t_func                  r_func, n_func;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic                   r_res_ok, n_res_ok;
    logic [OFFSET_BITS-1:0] r_res_offset, n_res_offset;
    logic [SIZE_BITS-1:0]   r_res_bytes, n_res_bytes;
    logic                   r_o_valid, n_o_valid;
    logic                   r_o_ok, n_o_ok;
    logic [OFFSET_BITS-1:0] r_o_offset, n_o_offset;
    logic [SIZE_BITS-1:0]   r_o_bytes, n_o_bytes;
    logic [SIZE_BITS-1:0]   r_region;

    // block table
    t_entry                 r_mem [MAX_BLOCKS];
    t_entry                 r_rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    t_entry                 mem_wdata;
    logic [AW-1:0]          mem_raddr;

    // shared compare datapath
    logic [CUR_BITS-1:0]    region_up;
    logic [CUR_BITS-1:0]    end_cap;
    logic [CUR_BITS-1:0]    ent_off;
    logic [CUR_BITS-1:0]    ent_top;
    logic [CUR_BITS-1:0]    lim;
    logic                   gap_fit;
    logic                   tail_fit;
    logic [CUR_BITS-1:0]    req_up;
    logic [CW-1:0]          idx_inc;
    logic                   apb_wr;

    // configuration register
    assign apb_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_BITS-1] == REG_REGION_BYTES)
                  ? PDATA_BITS'(r_region) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= REGION_RESET;
        end else if (apb_wr && paddr[PADDR_BITS-1] == REG_REGION_BYTES) begin
            r_region <= pwdata[SIZE_BITS-1:0];
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // gap checks against the entry just read
    assign region_up = round_up(CUR_BITS'(r_region));
    assign end_cap   = (region_up > REGION_CAP) ? REGION_CAP : region_up;
    assign req_up    = round_up(CUR_BITS'(i_req.request_bytes));
    assign ent_off   = CUR_BITS'(r_rd_data.offset);
    assign ent_top   = ent_off + CUR_BITS'(r_rd_data.size);
    assign lim       = (ent_off < r_end) ? ent_off : r_end;
    assign gap_fit   = (lim >= r_cursor) && ((lim - r_cursor) >= r_need);
    assign tail_fit  = (r_end >= r_cursor) && ((r_end - r_cursor) >= r_need);
    assign idx_inc   = r_idx + CW'(1);

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.ok             = r_o_ok;
    assign o_rsp.granted_offset = r_o_offset;
    assign o_rsp.found_bytes    = r_o_bytes;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_cursor     = r_cursor;
        n_need       = r_need;
        n_end        = r_end;
        n_func       = r_func;
        n_off        = r_off;
        n_res_ok     = r_res_ok;
        n_res_offset = r_res_offset;
        n_res_bytes  = r_res_bytes;
        n_o_valid    = r_o_valid;
        n_o_ok       = r_o_ok;
        n_o_offset   = r_o_offset;
        n_o_bytes    = r_o_bytes;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_wdata    = r_rd_data;
        mem_raddr    = idx_inc[AW-1:0];

        // output register drains on a transfer
        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                mem_raddr = '0;
                if (i_req.valid) begin
                    n_func       = i_req.func;
                    n_off        = i_req.target_offset;
                    n_need       = req_up;
                    n_end        = end_cap;
                    n_cursor     = '0;
                    n_idx        = '0;
                    n_res_ok     = 1'b0;
                    n_res_offset = '0;
                    n_res_bytes  = '0;
                    case (i_req.func)
                        FUNC_ALLOC: begin
                            if (i_req.request_bytes == '0
                                || r_count >= CW'(MAX_BLOCKS)) begin
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        FUNC_FREE, FUNC_QUERY: begin
                            n_state = ST_FIND;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            // walk the table for the first gap that holds the request
            ST_SCAN: begin
                if (r_idx >= r_count) begin
                    if (tail_fit) begin
                        n_pos     = r_count;
                        n_idx     = r_count;
                        mem_raddr = r_count[AW-1:0] - AW'(1);
                        n_state   = ST_INS;
                    end else begin
                        n_state   = ST_RESP;
                    end
                end else if (gap_fit) begin
                    n_pos     = r_idx;
                    n_idx     = r_count;
                    mem_raddr = r_count[AW-1:0] - AW'(1);
                    n_state   = ST_INS;
                end else begin
                    if (ent_top > r_cursor) begin
                        n_cursor = ent_top;
                    end
                    n_idx = idx_inc;
                end
            end

            // open a slot by moving entries up, then store the new block
            ST_INS: begin
                mem_we = 1'b1;
                if (r_idx == r_pos) begin
                    mem_wdata.offset = r_cursor[OFFSET_BITS-1:0];
                    mem_wdata.size   = r_need[SIZE_BITS-1:0];
                    n_count      = r_count + CW'(1);
                    n_res_ok     = 1'b1;
                    n_res_offset = r_cursor[OFFSET_BITS-1:0];
                    n_res_bytes  = r_need[SIZE_BITS-1:0];
                    n_state      = ST_RESP;
                end else begin
                    mem_raddr = r_idx[AW-1:0] - AW'(2);
                    n_idx     = r_idx - CW'(1);
                end
            end

            // search for the block at the target offset
            ST_FIND: begin
                if (r_idx >= r_count) begin
                    n_state = ST_RESP;
                end else if (r_rd_data.offset == r_off) begin
                    if (r_func == FUNC_QUERY) begin
                        n_res_ok    = 1'b1;
                        n_res_bytes = r_rd_data.size;
                        n_state     = ST_RESP;
                    end else begin
                        n_state     = ST_DEL;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end

            // close the gap by moving later entries down
            ST_DEL: begin
                if (idx_inc >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_res_ok = 1'b1;
                    n_state  = ST_RESP;
                end else begin
                    mem_we    = 1'b1;
                    mem_raddr = r_idx[AW-1:0] + AW'(2);
                    n_idx     = idx_inc;
                end
            end

            // hand the result to the output register
            ST_RESP: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_ok     = r_res_ok;
                    n_o_offset = r_res_offset;
                    n_o_bytes  = r_res_bytes;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_cursor     <= n_cursor;
        r_need       <= n_need;
        r_end        <= n_end;
        r_func       <= n_func;
        r_off        <= n_off;
        r_res_ok     <= n_res_ok;
        r_res_offset <= n_res_offset;
        r_res_bytes  <= n_res_bytes;
        r_o_ok       <= n_o_ok;
        r_o_offset   <= n_o_offset;
        r_o_bytes    <= n_o_bytes;
    end

endmodule
